// File: hw/rtl/bnlf_pkg.sv
// Package for the binary 3x3 neighborhood table filter.
// Holds sizes, register map constants and the result item type.
// No dependencies.
package bnlf_pkg;

    // Line buffer depth and index widths
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int FILL_W    = COL_W + 1;

    // Table held in eight 64-bit registers at byte address 8*i
    localparam int LUT_WORDS  = 8;
    localparam int LUT_WSEL_W = $clog2(LUT_WORDS);
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = LUT_WSEL_W + 3;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Input command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic pixel;
        logic row_end;
        logic frame_end;
    } out_item_t;

    // 9-bit neighborhood index; each column is {top, middle, bottom}
    function automatic logic [8:0] make_index(input logic [2:0] left,
                                              input logic [2:0] mid,
                                              input logic [2:0] right);
        make_index = {left[2], mid[2], right[2],
                      left[1], mid[1], right[1],
                      left[0], mid[0], right[0]};
    endfunction

endpackage

// File: hw/rtl/binary_neighborhood_lut_filter_core.sv
// Top level of the binary 3x3 neighborhood table filter.
// Depends on bnlf_pkg.
//
// Takes one one-bit pixel per clock in raster order and emits the filtered image one row
// late: each item yields the result one column to its left, and a row-end item also yields
// the last column of its row, so a row of W items gives W results and the output side keeps
// pace at one result per cycle. The input takes one item per cycle and stalls only when
// back-pressure leaves three or more results waiting in the four-entry result queue. The two
// lines above the current row live in one 2-bit wide,
// 1024-deep synchronous memory; the entry for the next column is read at the edge that
// takes the current item and is forwarded when both hit the same column. A fill count
// marks the columns written since reset, so unwritten entries read as zero with no
// clearing pass. After the image, send one row of drain items (cmd = 1); its row_end
// closes the frame. The table is written over the APB port, eight 64-bit words at byte
// address 8*i; the user must write it only while the block is idle; nothing enforces it.
module binary_neighborhood_lut_filter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // input pixel channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic                          pixel,
    input  logic                          row_end,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_pixel,
    output logic                          out_row_end,
    output logic                          out_frame_end,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bnlf_pkg::ADDR_W-1:0]   paddr,
    input  logic [bnlf_pkg::DATA_W-1:0]   pwdata,
    output logic [bnlf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import bnlf_pkg::*;

    // Table registers
    logic [DATA_W-1:0] lut_reg [LUT_WORDS];

    // Line memory: bit 1 upper line, bit 0 middle line
    logic [1:0]        line_mem [MAX_WIDTH];
    logic [1:0]        rd_data_reg;
    logic              rd_valid_reg;
    logic              rd_valid_next;

    // Scan state
    logic [COL_W-1:0]  col_reg, col_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [1:0]        rows_reg, rows_next;
    logic [5:0]        win_reg, win_next;

    // Result queue
    out_item_t         q_reg [QDEPTH];
    logic [QPTR_W-1:0] q_rd_reg, q_wr_reg;
    logic [QCNT_W-1:0] q_cnt_reg;

    logic              accept;
    logic              pop;
    logic [1:0]        line_rd;
    logic              top, mid, bot;
    logic [2:0]        cur, prev1, prev2;
    logic [8:0]        idx_a, idx_b;
    logic              col_nz;
    logic              has_a, has_b;
    out_item_t         res_a, res_b, ent0;
    logic [1:0]        push_n;
    logic [LUT_WSEL_W-1:0] cfg_sel;

    assign accept = in_valid && in_ready;
    assign pop    = out_valid && out_ready;

    // APB port
    assign pready  = 1'b1;
    assign cfg_sel = paddr[ADDR_W-1:3];
    assign prdata  = lut_reg[cfg_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LUT_WORDS; i++)
            begin
                lut_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite && pready)
        begin
            lut_reg[cfg_sel] <= pwdata;
        end
    end

    // Neighborhood for the current item
    always_comb
    begin
        line_rd = rd_valid_reg ? rd_data_reg : 2'b00;
        top     = (rows_reg >= 2'd2) ? line_rd[1] : 1'b0;
        mid     = (rows_reg >= 2'd1) ? line_rd[0] : 1'b0;
        bot     = (cmd == CMD_DRAIN) ? 1'b0 : pixel;
        cur     = {top, mid, bot};
        col_nz  = (col_reg != '0);
        prev2   = col_nz ? win_reg[5:3] : 3'b000;
        prev1   = col_nz ? win_reg[2:0] : 3'b000;
        idx_a   = make_index(prev2, prev1, cur);
        idx_b   = make_index(prev1, cur, 3'b000);

        res_a.pixel     = lut_reg[idx_a[8:6]][idx_a[5:0]];
        res_a.row_end   = 1'b0;
        res_a.frame_end = 1'b0;
        res_b.pixel     = lut_reg[idx_b[8:6]][idx_b[5:0]];
        res_b.row_end   = 1'b1;
        res_b.frame_end = (cmd == CMD_DRAIN);

        has_a  = (rows_reg != 2'd0) && col_nz;
        has_b  = (rows_reg != 2'd0) && row_end;
        ent0   = has_a ? res_a : res_b;
        push_n = accept ? (2'(has_a) + 2'(has_b)) : 2'd0;
    end

    // Next scan state
    always_comb
    begin
        win_next  = {prev1, cur};
        fill_next = fill_reg;
        if ({1'b0, col_reg} + 1'b1 > fill_reg)
        begin
            fill_next = {1'b0, col_reg} + 1'b1;
        end

        rows_next = rows_reg;
        if (row_end)
        begin
            col_next = '0;
            if (cmd == CMD_DRAIN)
            begin
                rows_next = 2'd0;
            end
            else if (rows_reg < 2'd2)
            begin
                rows_next = rows_reg + 2'd1;
            end
        end
        else if (col_reg < COL_W'(MAX_WIDTH - 1))
        begin
            col_next = col_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg;
        end

        // Entries past the fill count were never written and read as zero
        rd_valid_next = ({1'b0, col_next} < fill_next);
    end

    // Line memory: write this column, prefetch the next one, forward on a match
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_reg] <= {mid, bot};
            if (col_next == col_reg)
            begin
                rd_data_reg <= {mid, bot};
            end
            else
            begin
                rd_data_reg <= line_mem[col_next];
            end
        end
    end

    // Scan control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            fill_reg     <= '0;
            rows_reg     <= 2'd0;
            win_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg      <= col_next;
            fill_reg     <= fill_next;
            rows_reg     <= rows_next;
            win_reg      <= win_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q_reg[q_wr_reg] <= ent0;
        end
        if (push_n == 2'd2)
        begin
            q_reg[q_wr_reg + 1'b1] <= res_b;
        end
    end

    // Result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_rd_reg  <= '0;
            q_wr_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_wr_reg  <= q_wr_reg + QPTR_W'(push_n);
            q_rd_reg  <= q_rd_reg + QPTR_W'(pop);
            q_cnt_reg <= q_cnt_reg + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

    // Room for two results keeps the input open
    assign in_ready      = (q_cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign out_valid     = (q_cnt_reg != '0);
    assign out_pixel     = q_reg[q_rd_reg].pixel;
    assign out_row_end   = q_reg[q_rd_reg].row_end;
    assign out_frame_end = q_reg[q_rd_reg].frame_end;

endmodule

// File: hw/rtl/bnlf_checker.sv
// Port-level checks for the binary 3x3 neighborhood table filter.
// Bound to binary_neighborhood_lut_filter_core by the statement at the end of this file.
module bnlf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          out_pixel,
    input logic                          out_row_end,
    input logic                          out_frame_end,
    input logic                          pready
);

    // A stalled result transfer holds its item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel)
            && $stable(out_row_end) && $stable(out_frame_end))
        else $error("result changed while stalled");

    // Frame end only on the last pixel of a row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_frame_end |-> out_row_end)
        else $error("frame end without row end");

    // Input is held off only by results waiting downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending result");

    // Results appear only after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(in_valid && in_ready))
        else $error("result appeared with no input transfer");

    // The configuration port never waits
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind binary_neighborhood_lut_filter_core bnlf_checker u_bnlf_checker (.*);

// File: dv/binary_neighborhood_lut_filter_core_test.sv
// Self-checking testbench for binary_neighborhood_lut_filter_core: a directed row list, then
// random frames under random back-pressure, every result compared in order with a local model.
// Depends on bnlf_pkg and the core RTL.
`timescale 1ns / 1ps

module binary_neighborhood_lut_filter_core_test;
    import bnlf_pkg::*;

    localparam int CLK_HIGH      = 6;
    localparam int CLK_LOW       = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int RAND_ITEMS    = 1350;
    localparam int LONG_ROW      = MAX_WIDTH + 6;
    localparam int LONG_FRAME    = 5;
    localparam int STALL_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SHOW_LIMIT    = 10;
    localparam logic [DATA_W-1:0] CENTER_WORD = 64'hFFFF_0000_FFFF_0000;

    typedef enum logic [1:0] {LUT_ZERO, LUT_ONES, LUT_CENTER} lut_mode_t;

    // One input transfer, with the expected results where they are typed in
    typedef struct packed {
        lut_mode_t  mode;
        logic       c;
        logic       p;
        logic       r;
        logic       typed;
        logic [1:0] n;
        out_item_t  e0;
        out_item_t  e1;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                cmd;
    logic                pixel;
    logic                row_end;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                out_pixel;
    logic                out_row_end;
    logic                out_frame_end;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Model state
    logic [DATA_W-1:0]   lut_model [LUT_WORDS];
    logic                upper_model [MAX_WIDTH];
    logic                middle_model [MAX_WIDTH];
    logic [5:0]          window_model;
    logic [COL_W-1:0]    col_model;
    logic [1:0]          rows_model;

    out_item_t           filtered_due [$];
    stim_row_t           offered_items [$];
    stim_row_t           directed_rows [$];
    logic [DATA_W-1:0]   next_lut [LUT_WORDS];

    int                  fail_count = 0;
    int                  items_sent = 0;
    int                  cycle_count = 0;
    int                  hold_count = 0;
    bit                  steady = 1'b0;
    bit                  stall_done = 1'b0;
    logic                stall_go = 1'b0;

    binary_neighborhood_lut_filter_core DUT (.*);

    // Clock
    always
    begin
        #CLK_HIGH clk = 1'b1;
        #CLK_LOW  clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("binary_neighborhood_lut_filter_core regression: fail");
            $finish;
        end
    end

    function automatic out_item_t result_of(input logic p, input logic re, input logic fe);
        out_item_t o;
        o.pixel     = p;
        o.row_end   = re;
        o.frame_end = fe;
        return o;
    endfunction

    // 3x3 index, row-major, top-left lands in bit 8
    function automatic logic [8:0] nbr_index(input logic [2:0] lft, input logic [2:0] ctr,
                                             input logic [2:0] rgt);
        logic [8:0] idx;
        idx = '0;
        for (int b = 2; b >= 0; b--)
            idx = {idx[5:0], lft[b], ctr[b], rgt[b]};
        return idx;
    endfunction

    function automatic logic lut_lookup(input logic [8:0] idx);
        return lut_model[idx[8:6]][idx[5:0]];
    endfunction

    // Advance the model by one input transfer; returns up to two results
    task automatic filter_pixel(input logic c_cmd, input logic c_pix, input logic c_rend,
                                output int n, output out_item_t r0, output out_item_t r1);
        logic [COL_W-1:0] col;
        logic             top, mid, bot;
        logic [2:0]       cur, prev2, prev1;
        out_item_t        res [2];
        n   = 0;
        col = col_model;
        top = (rows_model >= 2) ? upper_model[col] : 1'b0;
        mid = (rows_model >= 1) ? middle_model[col] : 1'b0;
        bot = (c_cmd == CMD_DRAIN) ? 1'b0 : c_pix;
        cur = {top, mid, bot};
        if (col == 0)
        begin
            prev2 = '0;
            prev1 = '0;
        end
        else
        begin
            {prev2, prev1} = window_model;
        end
        res[0] = '0;
        res[1] = '0;
        if (rows_model >= 1)
        begin
            if (col != 0)
            begin
                res[n] = result_of(lut_lookup(nbr_index(prev2, prev1, cur)), 1'b0, 1'b0);
                n++;
            end
            if (c_rend)
            begin
                res[n] = result_of(lut_lookup(nbr_index(prev1, cur, 3'b000)), 1'b1,
                                   c_cmd == CMD_DRAIN);
                n++;
            end
        end
        upper_model[col]  = mid;
        middle_model[col] = bot;
        window_model      = {prev1, cur};
        if (c_rend)
        begin
            col_model = '0;
            if (c_cmd == CMD_DRAIN)
                rows_model = '0;
            else if (rows_model < 2)
                rows_model = rows_model + 1'b1;
        end
        else if (col < MAX_WIDTH - 1)
        begin
            col_model = col + 1'b1;
        end
        r0 = res[0];
        r1 = res[1];
    endtask

    task automatic log_mismatch(input string msg);
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Scoreboard: predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin : scoreboard
        int        n;
        out_item_t r0, r1, want;
        stim_row_t s;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                s = offered_items.pop_front();
                filter_pixel(cmd, pixel, row_end, n, r0, r1);
                if (s.typed)
                begin
                    n  = int'(s.n);
                    r0 = s.e0;
                    r1 = s.e1;
                end
                if (n > 0)
                    filtered_due.insert(filtered_due.size(), r0);
                if (n > 1)
                    filtered_due.insert(filtered_due.size(), r1);
            end
            if (out_valid && out_ready)
            begin
                if (filtered_due.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected result pixel=%b row_end=%b frame_end=%b",
                                           out_pixel, out_row_end, out_frame_end));
                end
                else
                begin
                    want = filtered_due.pop_front();
                    if (want.pixel !== out_pixel || want.row_end !== out_row_end ||
                        want.frame_end !== out_frame_end)
                        log_mismatch($sformatf(
                            "result mismatch: expected %b/%b/%b got %b/%b/%b (pixel/row/frame)",
                            want.pixel, want.row_end, want.frame_end,
                            out_pixel, out_row_end, out_frame_end));
                end
            end
        end
    end

    // Receiver: random idling, one long hold-off, and a steady stretch
    always @(posedge clk)
    begin
        if (hold_count > 0)
        begin
            hold_count--;
            out_ready <= 1'b0;
        end
        else if (stall_go && !stall_done)
        begin
            stall_done = 1'b1;
            hold_count = STALL_CYCLES;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= steady || ($urandom_range(99) >= 7);
        end
    end

    task automatic add_row(input lut_mode_t mode, input logic c, input logic p, input logic r,
                           input logic typed, input int n, input out_item_t e0,
                           input out_item_t e1);
        stim_row_t s;
        s.mode  = mode;
        s.c     = c;
        s.p     = p;
        s.r     = r;
        s.typed = typed;
        s.n     = n[1:0];
        s.e0    = e0;
        s.e1    = e1;
        directed_rows.insert(directed_rows.size(), s);
    endtask

    // Offer one input transfer and wait until it is taken
    task automatic send_item(input stim_row_t s);
        if (!steady && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= s.c;
        pixel    <= s.p;
        row_end  <= s.r;
        offered_items.insert(offered_items.size(), s);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // One row of random pixels; optionally one item carries the other command
    task automatic send_row(input int len, input logic row_cmd, input bit mixed,
                            input int density);
        stim_row_t s;
        int        flip;
        s    = '0;
        flip = $urandom_range(len - 1);
        for (int k = 0; k < len; k++)
        begin
            s.c = (mixed && k == flip) ? ~row_cmd : row_cmd;
            s.p = ($urandom_range(99) < density);
            s.r = (k == len - 1);
            send_item(s);
        end
    endtask

    // Let every pending result drain, then allow the pipeline to settle
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (filtered_due.size() != 0 || offered_items.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup and access cycle; the bus is released by the caller
    task automatic write_reg(input int idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 8);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        lut_model[idx] = data;
    endtask

    task automatic load_table();
        settle_idle();
        for (int w = 0; w < LUT_WORDS; w++)
            write_reg(w, next_lut[w]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic pick_table(input int choice);
        for (int w = 0; w < LUT_WORDS; w++)
        begin
            case (choice)
                0: next_lut[w] = '0;
                1: next_lut[w] = '1;
                2: next_lut[w] = CENTER_WORD;
                3: next_lut[w] = {$urandom, $urandom} & {$urandom, $urandom};
                4: next_lut[w] = {$urandom, $urandom} | {$urandom, $urandom};
                default: next_lut[w] = {$urandom, $urandom};
            endcase
        end
    endtask

    initial
    begin : stimulus
        lut_mode_t cur_mode;
        stim_row_t s;
        int        frame_no, rand_start, width, height, len, density;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        cmd      <= CMD_PIXEL;
        pixel    <= 1'b0;
        row_end  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        for (int w = 0; w < LUT_WORDS; w++)
            lut_model[w] = '0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_model[i]  = 1'b0;
            middle_model[i] = 1'b0;
        end
        window_model = '0;
        col_model    = '0;
        rows_model   = '0;

        // Reset table: every output pixel reads 0.
        // Drain with no image rows: nothing comes out.
        add_row(LUT_ZERO, CMD_DRAIN, 1'b0, 1'b1, 1'b1, 0, '0, '0);
        // 3x2 image, first row silent
        add_row(LUT_ZERO, CMD_PIXEL, 1'b1, 1'b0, 1'b1, 0, '0, '0);
        add_row(LUT_ZERO, CMD_PIXEL, 1'b0, 1'b0, 1'b1, 0, '0, '0);
        add_row(LUT_ZERO, CMD_PIXEL, 1'b1, 1'b1, 1'b1, 0, '0, '0);
        add_row(LUT_ZERO, CMD_PIXEL, 1'b1, 1'b0, 1'b1, 0, '0, '0);
        add_row(LUT_ZERO, CMD_PIXEL, 1'b1, 1'b0, 1'b1, 1,
                result_of(1'b0, 1'b0, 1'b0), '0);
        add_row(LUT_ZERO, CMD_PIXEL, 1'b0, 1'b1, 1'b1, 2, result_of(1'b0, 1'b0, 1'b0),
                result_of(1'b0, 1'b1, 1'b0));
        // drain row; its pixel value is ignored
        add_row(LUT_ZERO, CMD_DRAIN, 1'b0, 1'b0, 1'b1, 0, '0, '0);
        add_row(LUT_ZERO, CMD_DRAIN, 1'b1, 1'b0, 1'b1, 1,
                result_of(1'b0, 1'b0, 1'b0), '0);
        add_row(LUT_ZERO, CMD_DRAIN, 1'b0, 1'b1, 1'b1, 2, result_of(1'b0, 1'b0, 1'b0),
                result_of(1'b0, 1'b1, 1'b1));
        // All-ones table, single-column image: only row-end results
        add_row(LUT_ONES, CMD_PIXEL, 1'b1, 1'b1, 1'b1, 0, '0, '0);
        add_row(LUT_ONES, CMD_PIXEL, 1'b0, 1'b1, 1'b1, 1,
                result_of(1'b1, 1'b1, 1'b0), '0);
        add_row(LUT_ONES, CMD_DRAIN, 1'b0, 1'b1, 1'b1, 1,
                result_of(1'b1, 1'b1, 1'b1), '0);
        // Center-pixel table: ragged row, mixed commands, short drain row
        add_row(LUT_CENTER, CMD_PIXEL, 1'b1, 1'b0, 1'b0, 0, '0, '0);
        add_row(LUT_CENTER, CMD_PIXEL, 1'b1, 1'b0, 1'b0, 0, '0, '0);
        add_row(LUT_CENTER, CMD_PIXEL, 1'b0, 1'b0, 1'b0, 0, '0, '0);
        add_row(LUT_CENTER, CMD_PIXEL, 1'b1, 1'b1, 1'b0, 0, '0, '0);
        add_row(LUT_CENTER, CMD_PIXEL, 1'b0, 1'b0, 1'b0, 0, '0, '0);
        add_row(LUT_CENTER, CMD_DRAIN, 1'b1, 1'b0, 1'b0, 0, '0, '0);
        add_row(LUT_CENTER, CMD_PIXEL, 1'b1, 1'b1, 1'b0, 0, '0, '0);
        add_row(LUT_CENTER, CMD_DRAIN, 1'b0, 1'b0, 1'b0, 0, '0, '0);
        add_row(LUT_CENTER, CMD_DRAIN, 1'b1, 1'b0, 1'b0, 0, '0, '0);
        add_row(LUT_CENTER, CMD_DRAIN, 1'b0, 1'b1, 1'b0, 0, '0, '0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        cur_mode = LUT_ZERO;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].mode != cur_mode)
            begin
                cur_mode = directed_rows[i].mode;
                pick_table(cur_mode == LUT_ONES ? 1 : (cur_mode == LUT_CENTER ? 2 : 0));
                load_table();
            end
            send_item(directed_rows[i]);
        end

        // Random frames
        frame_no   = 0;
        rand_start = items_sent;
        while (items_sent - rand_start < RAND_ITEMS)
        begin
            if (frame_no == 0 || $urandom_range(3) == 0)
            begin
                pick_table($urandom_range(7));
                load_table();
            end
            steady  = (frame_no >= 10 && frame_no < 22);
            density = $urandom_range(100);
            if (frame_no == LONG_FRAME)
            begin
                // Overlong row saturates the column; receiver holds off meanwhile
                stall_go <= 1'b1;
                send_row(3, CMD_PIXEL, 1'b0, density);
                send_row(LONG_ROW, CMD_PIXEL, 1'b0, density);
                send_row(3, CMD_DRAIN, 1'b0, density);
            end
            else if ($urandom_range(9) == 0)
            begin
                // Noise: arbitrary field values
                repeat ($urandom_range(1, 24))
                begin
                    s   = '0;
                    s.c = $urandom_range(1);
                    s.p = $urandom_range(1);
                    s.r = ($urandom_range(3) == 0);
                    send_item(s);
                end
            end
            else
            begin
                width  = ($urandom_range(7) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(1, 12);
                height = $urandom_range(0, 5);
                for (int r = 0; r < height; r++)
                begin
                    len = ($urandom_range(6) == 0) ? $urandom_range(1, width + 3) : width;
                    send_row(len, CMD_PIXEL, $urandom_range(9) == 0, density);
                end
                len = ($urandom_range(6) == 0) ? $urandom_range(1, width + 3) : width;
                send_row(len, CMD_DRAIN, $urandom_range(19) == 0, density);
            end
            frame_no++;
        end
        steady = 1'b0;

        settle_idle();
        if (filtered_due.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", filtered_due.size()));
        if (fail_count == 0)
            $display("binary_neighborhood_lut_filter_core regression: pass");
        else
            $display("binary_neighborhood_lut_filter_core regression: fail");
        $finish;
    end

endmodule
